FILE: sv/esz_pkg.sv
// Package for the zero-width span marker: byte codes, register indexes,
// character class functions and the result pair type.
// No dependencies.
package esz_pkg;

    // Byte codes
    localparam logic [7:0] NUL_BYTE       = 8'h00;
    localparam logic [7:0] BEL_BYTE       = 8'h07;
    localparam logic [7:0] TAB_BYTE       = 8'h09;
    localparam logic [7:0] LF_BYTE        = 8'h0A;
    localparam logic [7:0] CR_BYTE        = 8'h0D;
    localparam logic [7:0] ESC_BYTE       = 8'h1B;
    localparam logic [7:0] SPACE_BYTE     = 8'h20;
    localparam logic [7:0] DEL_BYTE       = 8'h7F;
    localparam logic [7:0] LBRACKET_BYTE  = 8'h5B;
    localparam logic [7:0] RBRACKET_BYTE  = 8'h5D;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0] DCS_BYTE       = 8'h50;
    localparam logic [7:0] SOS_BYTE       = 8'h58;
    localparam logic [7:0] PM_BYTE        = 8'h5E;
    localparam logic [7:0] APC_BYTE       = 8'h5F;

    // Register map
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;
    localparam logic [7:0] START_MARKER_RST = 8'h01;
    localparam logic [7:0] END_MARKER_RST   = 8'h02;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    // One result beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    // Results of one item: one or two beats
    typedef struct packed {
        logic  two;
        t_beat first;
        t_beat second;
    } t_pair;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_control(input logic [7:0] c);
        return (c < SPACE_BYTE) || (c == DEL_BYTE);
    endfunction

    function automatic logic is_exempt(input logic [7:0] c);
        return (c == BEL_BYTE) || (c == ESC_BYTE) || (c == LF_BYTE) ||
               (c == CR_BYTE) || (c == TAB_BYTE);
    endfunction

    function automatic logic is_intro(input logic [7:0] c);
        return (c == DCS_BYTE) || (c == SOS_BYTE) || (c == PM_BYTE) || (c == APC_BYTE);
    endfunction

endpackage

FILE: sv/esz_core.sv
// Escape sequence tracker: parser state registers and the single-pass
// logic that turns one item into its one or two result beats.
// Depends on esz_pkg.
module esz_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_action,
    input  logic [7:0]    i_ch,
    input  logic [7:0]    i_start_marker,
    input  logic [7:0]    i_end_marker,
    output esz_pkg::t_pair o_pair
);
    import esz_pkg::*;

    logic r_esc, r_csi, r_osc, r_str, r_tp, r_span;
    logic n_esc, n_csi, n_osc, n_str, n_tp, n_span;
    logic done;
    logic start_emit;
    t_pair pair;

    // Next state and results, in the order the parser checks its cases
    always_comb begin
        n_esc      = r_esc;
        n_csi      = r_csi;
        n_osc      = r_osc;
        n_str      = r_str;
        n_tp       = r_tp;
        n_span     = r_span;
        done       = 1'b0;
        start_emit = 1'b0;
        pair       = '0;
        if (i_action == ACT_EOS) begin
            n_esc  = 1'b0;
            n_csi  = 1'b0;
            n_osc  = 1'b0;
            n_str  = 1'b0;
            n_tp   = 1'b0;
            n_span = 1'b0;
            if (r_span) begin
                pair.two    = 1'b1;
                pair.first  = '{data: i_end_marker, last: 1'b0};
                pair.second = '{data: NUL_BYTE, last: 1'b1};
            end else begin
                pair.first  = '{data: NUL_BYTE, last: 1'b1};
            end
        end else begin
            // ESC opens a span
            if (i_ch == ESC_BYTE) begin
                n_esc = 1'b1;
                if (!n_span) start_emit = 1'b1;
                n_span = 1'b1;
            end
            // sequence kind after ESC
            if (n_esc && i_ch == LBRACKET_BYTE) begin
                n_esc = 1'b0;
                n_csi = 1'b1;
            end
            if (n_esc && i_ch == RBRACKET_BYTE) begin
                n_esc = 1'b0;
                n_osc = 1'b1;
                n_str = 1'b1;
            end
            if (n_esc && is_intro(i_ch)) begin
                n_esc = 1'b0;
                n_str = 1'b1;
            end
            // two-byte escape: end marker, span stays marked open
            if (n_esc && is_letter(i_ch)) begin
                n_esc = 1'b0;
                done  = 1'b1;
            end
            // other non-printing controls
            if (!done && is_control(i_ch) && !is_exempt(i_ch)) begin
                if (!n_span) start_emit = 1'b1;
                n_span = 1'b1;
            end
            // CSI final letter
            if (!done && n_csi && is_letter(i_ch)) begin
                n_csi  = 1'b0;
                n_span = 1'b0;
                done   = 1'b1;
            end
            // OSC ended by BEL
            if (!done && n_osc && i_ch == BEL_BYTE) begin
                n_osc  = 1'b0;
                n_str  = 1'b0;
                n_span = 1'b0;
                done   = 1'b1;
            end
            // string terminator ESC backslash
            if (!done && n_tp) begin
                if (i_ch == BACKSLASH_BYTE) begin
                    n_str  = 1'b0;
                    n_span = 1'b0;
                    done   = 1'b1;
                end
                n_tp = 1'b0;
            end
            if (done) begin
                pair.two    = 1'b1;
                pair.first  = '{data: i_ch, last: 1'b0};
                pair.second = '{data: i_end_marker, last: 1'b0};
            end else begin
                if (n_str && i_ch == ESC_BYTE) n_tp = 1'b1;
                if (start_emit) begin
                    pair.two    = 1'b1;
                    pair.first  = '{data: i_start_marker, last: 1'b0};
                    pair.second = '{data: i_ch, last: 1'b0};
                end else begin
                    pair.first  = '{data: i_ch, last: 1'b0};
                end
            end
        end
    end

    assign o_pair = pair;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_csi  <= 1'b0;
            r_osc  <= 1'b0;
            r_str  <= 1'b0;
            r_tp   <= 1'b0;
            r_span <= 1'b0;
        end else if (i_step) begin
            r_esc  <= n_esc;
            r_csi  <= n_csi;
            r_osc  <= n_osc;
            r_str  <= n_str;
            r_tp   <= n_tp;
            r_span <= n_span;
        end
    end

endmodule

FILE: sv/esz_outbuf.sv
// Result register: holds the one or two beats of an item and hands them
// out in order on the stall-controlled result channel.
// Depends on esz_pkg.
module esz_outbuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  esz_pkg::t_pair i_pair,
    output logic           o_space,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_data,
    output logic           o_last
);
    import esz_pkg::*;

    logic [1:0] r_cnt;
    t_beat      r_e0, r_e1;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_space = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_data  = r_e0.data;
    assign o_last  = r_e0.last;

    // Beat count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_pair.two ? 2'd2 : 2'd1;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Beat payload, head in entry 0
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_e0 <= i_pair.first;
            r_e1 <= i_pair.second;
        end else if (pop) begin
            r_e0 <= r_e1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_load_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop)))
        else $error("result loaded over a pending beat");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_e0.last)
        else $error("first beat of a pair flagged last");

    a_pair_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_pair.two) |=> (o_valid && (r_cnt == 2'd2)))
        else $error("two-beat result not held");

endmodule

FILE: sv/escape_sequence_zero_width_marker.sv
// Top level of the zero-width span marker: input register, configuration
// registers, parser core and result register.
// Depends on esz_pkg, esz_core, esz_outbuf.
//
// Usage:
//   Input channel (i_valid / o_stall, i_action, i_ch) takes one prompt byte
//   (action 0) or an end-of-string beat (action 1) per beat. Result channel
//   (o_valid / i_stall, o_out_byte, o_is_last) gives the copied bytes with
//   start and end marker bytes around escape sequences and non-printing
//   controls; the NUL terminator after end of string carries o_is_last.
//   Markers are set through the configuration channel (i_cfg_valid /
//   o_cfg_ready, index 0 = start marker, 1 = end marker); o_cfg_ready is
//   always high. Write them only while the block is idle.
//   An item accepted into the input register goes through the parser core
//   into the result register, from which its first result beat is shown.
//   The result register takes a new item only once it is empty or its last
//   beat is being taken, so an item that gives two beats holds back the next.
//   Reset clears the parser state, sets the markers to 1 and 2 and empties
//   both registers. When the receiver stalls, the result holds and the
//   input register fills, after which o_stall rises.
module escape_sequence_zero_width_marker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [7:0]                    i_ch,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_is_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esz_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import esz_pkg::*;

    logic       r_in_vld;
    logic       r_in_action;
    logic [7:0] r_in_ch;
    logic [7:0] r_start_marker, r_end_marker;
    logic       in_take, adv, space;
    t_pair      pair;

    assign o_cfg_ready = 1'b1;
    assign adv         = r_in_vld && space;
    assign o_stall     = r_in_vld && !space;
    assign in_take     = i_valid && !o_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_action;
            r_in_ch     <= i_ch;
        end
    end

    esz_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (adv),
        .i_action       (r_in_action),
        .i_ch           (r_in_ch),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_pair         (pair)
    );

    esz_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_pair  (pair),
        .o_space (space),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_out_byte),
        .o_last  (o_is_last)
    );

endmodule
